// File: hw/rtl/pli_pkg.sv
// Package with the shared types, codes and constants of the interpolation table.
`default_nettype none

package pli_pkg;

    localparam int MAX_POINTS_DEF = 64;

    // Request codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_STATS  = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_DUP   = 3'd1;
    localparam logic [2:0] ST_FULL  = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_BELOW = 3'd4;
    localparam logic [2:0] ST_ABOVE = 3'd5;
    localparam logic [2:0] ST_ZERO  = 3'd6;

    // Result value selection.
    localparam logic [2:0] VS_ZERO   = 3'd0;
    localparam logic [2:0] VS_YLAST  = 3'd1;
    localparam logic [2:0] VS_INTERP = 3'd2;
    localparam logic [2:0] VS_MEAN   = 3'd3;
    localparam logic [2:0] VS_STATZ  = 3'd4;

    // Read address selection.
    localparam logic [1:0] RA_IDX  = 2'd0;
    localparam logic [1:0] RA_PREV = 2'd1;
    localparam logic [1:0] RA_LAST = 2'd2;

    localparam logic [31:0] MEAN_NEG_LIM = 32'h8000_0000;
    localparam logic [31:0] MEAN_POS_LIM = 32'h7FFF_FFFF;

    localparam int OUT_DATA_W = 168;

    typedef struct packed {
        logic       load_in;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       idx_inc;
        logic       idx_dec;
        logic       idx_from_cnt;
        logic       pos_load;
        logic [1:0] ra_sel;
        logic       we;
        logic       wa_pos;
        logic       prev_load;
        logic       first_load;
        logic       mm_update;
        logic       seg_q;
        logic       seg_s;
        logic       mul;
        logic       h_calc;
        logic       acc;
        logic       odd_fin;
        logic       abs_rng;
        logic       div_start;
        logic       div_step;
        logic       finish;
        logic [2:0] fin_st;
        logic [2:0] fin_vs;
        logic       out_load;
    } pli_cmd_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       idx_eq_cnt;
        logic       idx_eq_pos;
        logic       idx_zero;
        logic       cnt_zero;
        logic       cnt_full;
        logic       rx_eq_xin;
        logic       rx_lt_xin;
        logic       rx_gt_xin;
        logic       div_last;
        logic       mean_ovf;
        logic       range_zero;
    } pli_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/pli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pli_ctrl.sv
// Sequencer of the interpolation table: walks insert, query and statistics requests.
`default_nettype none

module pli_ctrl
    import pli_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire pli_stat_t st,
    output pli_cmd_t       cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_I_RD   = 5'd2;
    localparam logic [4:0] S_I_CHK  = 5'd3;
    localparam logic [4:0] S_I_FULL = 5'd4;
    localparam logic [4:0] S_SH_RD  = 5'd5;
    localparam logic [4:0] S_SH_WR  = 5'd6;
    localparam logic [4:0] S_Q_0    = 5'd7;
    localparam logic [4:0] S_Q_L    = 5'd8;
    localparam logic [4:0] S_Q_RD   = 5'd9;
    localparam logic [4:0] S_Q_CHK  = 5'd10;
    localparam logic [4:0] S_Q_MUL  = 5'd11;
    localparam logic [4:0] S_Q_DLD  = 5'd12;
    localparam logic [4:0] S_Q_DIV  = 5'd13;
    localparam logic [4:0] S_Q_RES  = 5'd14;
    localparam logic [4:0] S_S_USE  = 5'd15;
    localparam logic [4:0] S_S_MUL  = 5'd16;
    localparam logic [4:0] S_S_H    = 5'd17;
    localparam logic [4:0] S_S_ACC  = 5'd18;
    localparam logic [4:0] S_S_NEXT = 5'd19;
    localparam logic [4:0] S_S_FIN  = 5'd20;
    localparam logic [4:0] S_S_ABS  = 5'd21;
    localparam logic [4:0] S_S_RNG  = 5'd22;
    localparam logic [4:0] S_S_DIV  = 5'd23;
    localparam logic [4:0] S_S_MEAN = 5'd24;
    localparam logic [4:0] S_OUT    = 5'd25;

    logic [4:0] state_reg, state_next;
    logic       ovalid_reg, ovalid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd.ra_sel  = RA_IDX;
        cmd.fin_st  = ST_OK;
        cmd.fin_vs  = VS_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (st.cmd)
                    CMD_CLEAR:
                    begin
                        cmd.cnt_clr = 1'b1;
                        cmd.finish  = 1'b1;
                        state_next  = S_OUT;
                    end
                    CMD_INSERT:
                    begin
                        state_next = S_I_RD;
                    end
                    CMD_QUERY:
                    begin
                        if (st.cnt_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fin_st = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_Q_0;
                        end
                    end
                    default:
                    begin
                        if (st.cnt_zero)
                        begin
                            cmd.finish = 1'b1;
                            cmd.fin_st = ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_S_USE;
                        end
                    end
                endcase
            end
            S_I_RD:
            begin
                if (st.idx_eq_cnt)
                begin
                    cmd.pos_load = 1'b1;
                    state_next   = S_I_FULL;
                end
                else
                begin
                    state_next = S_I_CHK;
                end
            end
            S_I_CHK:
            begin
                priority if (st.rx_eq_xin)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_st = ST_DUP;
                    state_next = S_OUT;
                end
                else if (st.rx_lt_xin)
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_I_RD;
                end
                else
                begin
                    cmd.pos_load = 1'b1;
                    state_next   = S_I_FULL;
                end
            end
            S_I_FULL:
            begin
                if (st.cnt_full)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_st = ST_FULL;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.idx_from_cnt = 1'b1;
                    state_next       = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (st.idx_eq_pos)
                begin
                    cmd.we      = 1'b1;
                    cmd.wa_pos  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    cmd.finish  = 1'b1;
                    state_next  = S_OUT;
                end
                else
                begin
                    cmd.ra_sel = RA_PREV;
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.we      = 1'b1;
                cmd.idx_dec = 1'b1;
                state_next  = S_SH_RD;
            end
            S_Q_0:
            begin
                if (!st.rx_lt_xin && !st.rx_eq_xin)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_st = ST_BELOW;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.ra_sel    = RA_LAST;
                    state_next    = S_Q_L;
                end
            end
            S_Q_L:
            begin
                priority if (st.rx_lt_xin)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_st = ST_ABOVE;
                    state_next = S_OUT;
                end
                else if (st.rx_eq_xin)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_vs = VS_YLAST;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_Q_RD;
                end
            end
            S_Q_RD:
            begin
                state_next = S_Q_CHK;
            end
            S_Q_CHK:
            begin
                if (st.rx_gt_xin)
                begin
                    cmd.seg_q  = 1'b1;
                    state_next = S_Q_MUL;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_Q_RD;
                end
            end
            S_Q_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_Q_DLD;
            end
            S_Q_DLD:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_Q_DIV;
            end
            S_Q_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_Q_RES;
                end
            end
            S_Q_RES:
            begin
                cmd.finish = 1'b1;
                cmd.fin_vs = VS_INTERP;
                state_next = S_OUT;
            end
            S_S_USE:
            begin
                cmd.prev_load = 1'b1;
                if (st.idx_zero)
                begin
                    cmd.first_load = 1'b1;
                    cmd.idx_inc    = 1'b1;
                    state_next     = S_S_NEXT;
                end
                else
                begin
                    cmd.mm_update = 1'b1;
                    cmd.seg_s     = 1'b1;
                    state_next    = S_S_MUL;
                end
            end
            S_S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_S_H;
            end
            S_S_H:
            begin
                cmd.h_calc = 1'b1;
                state_next = S_S_ACC;
            end
            S_S_ACC:
            begin
                cmd.acc     = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_S_NEXT;
            end
            S_S_NEXT:
            begin
                if (st.idx_eq_cnt)
                begin
                    state_next = S_S_FIN;
                end
                else
                begin
                    state_next = S_S_USE;
                end
            end
            S_S_FIN:
            begin
                cmd.odd_fin = 1'b1;
                state_next  = S_S_ABS;
            end
            S_S_ABS:
            begin
                cmd.abs_rng = 1'b1;
                state_next  = S_S_RNG;
            end
            S_S_RNG:
            begin
                if (st.range_zero)
                begin
                    cmd.finish = 1'b1;
                    cmd.fin_st = ST_ZERO;
                    cmd.fin_vs = VS_STATZ;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = st.mean_ovf ? S_S_MEAN : S_S_DIV;
                end
            end
            S_S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = S_S_MEAN;
                end
            end
            S_S_MEAN:
            begin
                cmd.finish = 1'b1;
                cmd.fin_vs = VS_MEAN;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ovalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/pli_dp.sv
// Datapath of the interpolation table: point memories, multiplier, divider, accumulator.
`default_nettype none

module pli_dp
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic [1:0]            in_cmd,
    input  wire logic [63:0]           in_data,
    input  wire pli_cmd_t              cmd,
    output pli_stat_t                  st,
    output logic      [2:0]            out_status,
    output logic      [OUT_DATA_W-1:0] out_data
);

    localparam int IDX_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        begin
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
            begin
                sat_add = s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
            end
            else
            begin
                sat_add = s[63:0];
            end
        end
    endfunction

    logic [1:0]        cmd_reg;
    logic signed [31:0] xin_reg, yin_reg;
    logic [CNT_W-1:0]  cnt_reg, idx_reg, pos_reg, odd_reg;
    logic signed [31:0] x0_reg, xp_reg, yp_reg, mn_reg, mx_reg;
    logic [31:0]       ma_reg, dvs_reg, rem_reg, dl_reg, q_reg;
    logic [32:0]       mb_reg;
    logic              neg_reg;
    logic [63:0]       prod_reg, h_reg, sum_reg;
    logic [4:0]        dcnt_reg;
    logic [2:0]        res_st_reg;
    logic [31:0]       res_val_reg, res_mn_reg, res_mx_reg;
    logic [63:0]       res_int_reg;
    logic [2:0]        o_st_reg;
    logic [31:0]       o_val_reg, o_mn_reg, o_mx_reg;
    logic [63:0]       o_int_reg;
    logic [6:0]        o_cnt_reg;

    logic signed [31:0] rx, ry;
    logic [CNT_W-1:0]  raddr_full, waddr_full;
    logic [31:0]       wx, wy;
    logic [32:0]       dy, sy, rem_sh;
    logic [31:0]       qlim, mean_val;
    logic [CNT_W+6:0]  cnt_ext;

    always_comb
    begin
        unique case (cmd.ra_sel)
            RA_PREV: raddr_full = idx_reg - CNT_W'(1);
            RA_LAST: raddr_full = cnt_reg - CNT_W'(1);
            default: raddr_full = idx_reg;
        endcase
    end

    assign waddr_full = cmd.wa_pos ? pos_reg : idx_reg;
    assign wx = cmd.wa_pos ? xin_reg : rx;
    assign wy = cmd.wa_pos ? yin_reg : ry;

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_xram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr_full[IDX_W-1:0]),
        .wdata (wx),
        .raddr (raddr_full[IDX_W-1:0]),
        .rdata (rx)
    );

    pli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_yram (
        .clk   (clk),
        .we    (cmd.we),
        .waddr (waddr_full[IDX_W-1:0]),
        .wdata (wy),
        .raddr (raddr_full[IDX_W-1:0]),
        .rdata (ry)
    );

    assign dy     = {ry[31], ry} - {yp_reg[31], yp_reg};
    assign sy     = {ry[31], ry} + {yp_reg[31], yp_reg};
    assign rem_sh = {rem_reg, dl_reg[31]};

    always_comb
    begin
        qlim = (q_reg > MEAN_NEG_LIM) ? MEAN_NEG_LIM : q_reg;
        if (sum_reg[63])
        begin
            mean_val = 32'd0 - qlim;
        end
        else
        begin
            mean_val = (q_reg > MEAN_POS_LIM) ? MEAN_POS_LIM : q_reg;
        end
    end

    always_comb
    begin
        st.cmd        = cmd_reg;
        st.idx_eq_cnt = (idx_reg == cnt_reg);
        st.idx_eq_pos = (idx_reg == pos_reg);
        st.idx_zero   = (idx_reg == '0);
        st.cnt_zero   = (cnt_reg == '0);
        st.cnt_full   = (cnt_reg == CNT_W'(MAX_POINTS));
        st.rx_eq_xin  = (rx == xin_reg);
        st.rx_lt_xin  = (rx < xin_reg);
        st.rx_gt_xin  = (rx > xin_reg);
        st.div_last   = (dcnt_reg == 5'd31);
        st.mean_ovf   = (prod_reg[63:32] >= dvs_reg);
        st.range_zero = (dvs_reg == 32'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            priority if (cmd.load_in)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_from_cnt)
            begin
                idx_reg <= cnt_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= in_cmd;
            xin_reg <= in_data[31:0];
            yin_reg <= in_data[63:32];
        end
        if (cmd.pos_load)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.prev_load)
        begin
            xp_reg <= rx;
            yp_reg <= ry;
        end
        if (cmd.first_load)
        begin
            x0_reg  <= rx;
            mn_reg  <= ry;
            mx_reg  <= ry;
            sum_reg <= 64'd0;
            odd_reg <= '0;
        end
        if (cmd.mm_update)
        begin
            if (ry < mn_reg)
            begin
                mn_reg <= ry;
            end
            if (ry > mx_reg)
            begin
                mx_reg <= ry;
            end
        end
        if (cmd.seg_q)
        begin
            ma_reg  <= xin_reg - xp_reg;
            dvs_reg <= rx - xp_reg;
            neg_reg <= dy[32];
            mb_reg  <= dy[32] ? (33'd0 - dy) : dy;
        end
        if (cmd.seg_s)
        begin
            ma_reg  <= rx - xp_reg;
            neg_reg <= sy[32];
            mb_reg  <= sy[32] ? (33'd0 - sy) : sy;
        end
        if (cmd.mul)
        begin
            prod_reg <= 64'({33'd0, ma_reg} * {32'd0, mb_reg});
        end
        if (cmd.h_calc)
        begin
            // The odd halves are collected separately and added once at the end.
            h_reg   <= neg_reg ? (64'd0 - ({1'b0, prod_reg[63:1]} + 64'(prod_reg[0])))
                               : {1'b0, prod_reg[63:1]};
            odd_reg <= odd_reg + CNT_W'(prod_reg[0]);
        end
        if (cmd.acc)
        begin
            sum_reg <= sat_add(sum_reg, h_reg);
        end
        if (cmd.odd_fin)
        begin
            sum_reg <= sat_add(sum_reg, 64'(odd_reg >> 1));
        end
        if (cmd.abs_rng)
        begin
            prod_reg <= sum_reg[63] ? (64'd0 - sum_reg) : sum_reg;
            dvs_reg  <= xp_reg - x0_reg;
        end
        if (cmd.div_start)
        begin
            rem_reg  <= prod_reg[63:32];
            dl_reg   <= prod_reg[31:0];
            dcnt_reg <= 5'd0;
            q_reg    <= st.mean_ovf ? MEAN_NEG_LIM : 32'd0;
        end
        if (cmd.div_step)
        begin
            dl_reg   <= {dl_reg[30:0], 1'b0};
            dcnt_reg <= dcnt_reg + 5'd1;
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_reg <= 32'(rem_sh - {1'b0, dvs_reg});
                q_reg   <= {q_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[31:0];
                q_reg   <= {q_reg[30:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            res_st_reg <= cmd.fin_st;
            unique case (cmd.fin_vs)
                VS_YLAST:
                begin
                    res_val_reg <= ry;
                    res_int_reg <= 64'd0;
                    res_mn_reg  <= 32'd0;
                    res_mx_reg  <= 32'd0;
                end
                VS_INTERP:
                begin
                    res_val_reg <= neg_reg ? (yp_reg - q_reg) : (yp_reg + q_reg);
                    res_int_reg <= 64'd0;
                    res_mn_reg  <= 32'd0;
                    res_mx_reg  <= 32'd0;
                end
                VS_MEAN:
                begin
                    res_val_reg <= mean_val;
                    res_int_reg <= sum_reg;
                    res_mn_reg  <= mn_reg;
                    res_mx_reg  <= mx_reg;
                end
                VS_STATZ:
                begin
                    res_val_reg <= 32'd0;
                    res_int_reg <= sum_reg;
                    res_mn_reg  <= mn_reg;
                    res_mx_reg  <= mx_reg;
                end
                default:
                begin
                    res_val_reg <= 32'd0;
                    res_int_reg <= 64'd0;
                    res_mn_reg  <= 32'd0;
                    res_mx_reg  <= 32'd0;
                end
            endcase
        end
        if (cmd.out_load)
        begin
            o_st_reg  <= res_st_reg;
            o_val_reg <= res_val_reg;
            o_int_reg <= res_int_reg;
            o_mn_reg  <= res_mn_reg;
            o_mx_reg  <= res_mx_reg;
            o_cnt_reg <= cnt_ext[6:0];
        end
    end

    assign cnt_ext    = {7'd0, cnt_reg};
    assign out_status = o_st_reg;
    assign out_data   = {1'b0, o_cnt_reg, o_mx_reg, o_mn_reg, o_int_reg, o_val_reg};

endmodule

`default_nettype wire

// File: hw/rtl/piecewise_linear_interpolator.sv
// Top level of the piecewise linear interpolation table.
//
// Requests arrive on the s_axis channel: tuser carries the command (clear,
// insert, interpolate, statistics) and tdata the x and y arguments. Every
// request yields exactly one result on the m_axis channel, with the status
// in tuser and value, integral, minimum, maximum and point count in tdata.
// One request is processed at a time; the next one is taken as soon as the
// previous result sits in the output register, even if it is still waiting.
// The point memories have a single read port and are walked one entry at a
// time; interpolate and statistics requests also use the 32-step restoring
// divider. Reset empties the table and drops any pending result. When the
// receiver holds m_axis_tready low, the result is held and one more request
// can be processed up to its result, after which the block waits.
`default_nettype none

module piecewise_linear_interpolator
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [63:0]           s_axis_tdata,  // x_value, y_value
    input  wire logic [1:0]            s_axis_tuser,  // command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // value, integral, min_value, max_value, point_count, zero pad
    output logic      [OUT_DATA_W-1:0] m_axis_tdata,
    output logic      [2:0]            m_axis_tuser   // status
);

    pli_cmd_t  cmd;
    pli_stat_t st;

    pli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .st        (st),
        .cmd       (cmd)
    );

    pli_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_cmd     (s_axis_tuser),
        .in_data    (s_axis_tdata),
        .cmd        (cmd),
        .st         (st),
        .out_status (m_axis_tuser),
        .out_data   (m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/pli_checker.sv
// Port-level checker for the interpolation table, bound to the top level.
`default_nettype none

module pli_checker
    import pli_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [2:0]            m_axis_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while another is in progress");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_ZERO)
        else $error("status code out of range");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == ST_EMPTY
            |-> m_axis_tdata[166:160] == 7'd0 && m_axis_tdata[31:0] == 32'd0)
        else $error("empty status with stored points or a value");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the piecewise linear interpolation table.
`timescale 1ns / 100ps

module tb_top
    import pli_pkg::*;
();

    localparam int TABLE_DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1450;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] value;
        logic [63:0] integral;
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic [6:0]  point_count;
    } table_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = CMD_CLEAR;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;

    // Our own copy of the sorted table.
    int table_x [TABLE_DEPTH];
    int table_y [TABLE_DEPTH];
    int table_count = 0;

    table_result_t expected_results [$];
    int error_count = 0;
    int items_sent = 0;
    int idle_cycles = 0;
    int sink_stall = 0;
    bit quiet = 1'b0;

    always #5 clk = ~clk;

    piecewise_linear_interpolator dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    function automatic longint sat_add(longint a, longint b);
        longint sum;
        sum = a + b;
        if (b > 0 && sum < a)
            return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (b < 0 && sum > a)
            return 64'sh8000_0000_0000_0000;
        return sum;
    endfunction

    // Applies one request to the local table and returns the result it must produce.
    function automatic table_result_t predict_table_result(logic [1:0] cmd, int x, int y);
        table_result_t r;
        int pos;
        int k;
        int n;
        longint dy;
        longint sy;
        longint h;
        longint sum_h;
        bit [63:0] mag;
        bit [63:0] dx;
        bit [63:0] t;
        bit [63:0] q;
        bit [63:0] m;
        bit [63:0] range;
        bit [63:0] imag;
        int mn;
        int mx;
        int odd;
        longint res;
        r = '0;
        n = table_count;
        r.status = ST_OK;
        if (cmd == CMD_CLEAR) begin
            table_count = 0;
        end else if (cmd == CMD_INSERT) begin
            pos = 0;
            while (pos < n && table_x[pos] < x)
                pos++;
            if (pos < n && table_x[pos] == x) begin
                r.status = ST_DUP;
            end else if (n >= TABLE_DEPTH) begin
                r.status = ST_FULL;
            end else begin
                for (int i = n; i > pos; i--) begin
                    table_x[i] = table_x[i-1];
                    table_y[i] = table_y[i-1];
                end
                table_x[pos] = x;
                table_y[pos] = y;
                table_count = n + 1;
            end
        end else if (n == 0) begin
            r.status = ST_EMPTY;
        end else if (cmd == CMD_QUERY) begin
            if (x < table_x[0]) begin
                r.status = ST_BELOW;
            end else if (x > table_x[n-1]) begin
                r.status = ST_ABOVE;
            end else if (x == table_x[n-1]) begin
                r.value = table_y[n-1];
            end else begin
                k = 0;
                while (k + 2 < n && table_x[k+1] <= x)
                    k++;
                dy = longint'(table_y[k+1]) - longint'(table_y[k]);
                dx = longint'(table_x[k+1]) - longint'(table_x[k]);
                t = longint'(x) - longint'(table_x[k]);
                mag = (dy < 0) ? -dy : dy;
                q = (dx != 0) ? (mag * t) / dx : 64'd0;
                res = (dy < 0) ? longint'(table_y[k]) - longint'(q)
                               : longint'(table_y[k]) + longint'(q);
                r.value = res[31:0];
            end
        end else begin
            mn = table_y[0];
            mx = table_y[0];
            sum_h = 0;
            odd = 0;
            for (int i = 0; i < n; i++) begin
                if (table_y[i] < mn) mn = table_y[i];
                if (table_y[i] > mx) mx = table_y[i];
            end
            for (int i = 0; i + 1 < n; i++) begin
                dx = longint'(table_x[i+1]) - longint'(table_x[i]);
                sy = longint'(table_y[i]) + longint'(table_y[i+1]);
                m = dx * ((sy < 0) ? -sy : sy);
                if (sy < 0)
                    h = -longint'((m >> 1) + m[0]);
                else
                    h = longint'(m >> 1);
                sum_h = sat_add(sum_h, h);
                odd += m[0];
            end
            sum_h = sat_add(sum_h, longint'(odd >> 1));
            range = longint'(table_x[n-1]) - longint'(table_x[0]);
            if (range == 0) begin
                r.status = ST_ZERO;
            end else begin
                imag = (sum_h < 0) ? -sum_h : sum_h;
                q = imag / range;
                if (q > 64'h8000_0000) q = 64'h8000_0000;
                if (sum_h < 0)
                    r.value = -q[31:0];
                else
                    r.value = (q > 64'h7FFF_FFFF) ? MEAN_POS_LIM : q[31:0];
            end
            r.integral = sum_h;
            r.min_value = mn;
            r.max_value = mx;
        end
        r.point_count = table_count[6:0];
        return r;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s at %0t: got %h, expected %h", field, $realtime, got, want);
        error_count++;
    endtask

    // Sends one request; tvalid stays high after acceptance so back-to-back items need
    // only one assignment per time step.
    task automatic send_request(logic [1:0] cmd, int x, int y);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.insert(expected_results.size(), predict_table_result(cmd, x, y));
        items_sent++;
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver with random back-pressure per result.
    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                sink_stall = quiet ? 0 : $urandom_range(0, 12);
                m_axis_tready <= (sink_stall == 0);
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= (sink_stall == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        table_result_t want;
        if (m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $display("result with no request pending at %0t", $realtime);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_axis_tuser !== want.status)
                    report("status", m_axis_tuser, want.status);
                if (m_axis_tdata[31:0] !== want.value)
                    report("value", m_axis_tdata[31:0], want.value);
                if (m_axis_tdata[95:32] !== want.integral)
                    report("integral", m_axis_tdata[95:32], want.integral);
                if (m_axis_tdata[127:96] !== want.min_value)
                    report("min_value", m_axis_tdata[127:96], want.min_value);
                if (m_axis_tdata[159:128] !== want.max_value)
                    report("max_value", m_axis_tdata[159:128], want.max_value);
                if (m_axis_tdata[166:160] !== want.point_count)
                    report("point_count", m_axis_tdata[166:160], want.point_count);
            end
        end
    end

    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(CMD_CLEAR, 0, 0);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_STATS, 0, 0);
        send_request(CMD_INSERT, 0, 32'h0005_0000);
        // A single point has no range: stats flag it, and a query at its x answers its y.
        send_request(CMD_STATS, 0, 0);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_QUERY, -1, 0);
        send_request(CMD_QUERY, 1, 0);
        send_request(CMD_INSERT, 0, 7);
        send_request(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(CMD_QUERY, 32'h0000_8000, 0);
        send_request(CMD_QUERY, 32'h7FFF_FFFF, 0);
        send_request(CMD_QUERY, 32'h8000_0000, 0);
        send_request(CMD_QUERY, 32'hC000_0000, 0);
        send_request(CMD_STATS, 0, 0);
        send_request(CMD_INSERT, 32'h0001_0000, 32'h8000_0000);
        send_request(CMD_QUERY, 32'h0000_C000, 0);
        send_request(CMD_QUERY, 32'h4000_0000, 0);
        send_request(CMD_STATS, 0, 0);
        send_request(CMD_CLEAR, 0, 0);
        send_request(CMD_QUERY, 0, 0);
        send_request(CMD_STATS, 0, 0);
    endtask

    task automatic test_full_table();
        int first_x;
        send_request(CMD_CLEAR, 0, 0);
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_request(CMD_INSERT, (i - 32) * 65536000 + $urandom_range(0, 65535),
                         $urandom);
        first_x = table_x[0];
        send_request(CMD_INSERT, first_x, 0);
        send_request(CMD_INSERT, 32'h7FFF_FFFF, 0);
        send_request(CMD_STATS, 0, 0);
        send_request(CMD_QUERY, table_x[40] + 12345, 0);
        send_request(CMD_QUERY, table_x[TABLE_DEPTH-1], 0);
        // Let the table go completely idle once before the random part.
        wait_for_results();
        send_request(CMD_STATS, 0, 0);
    endtask

    function automatic int pick_query_x();
        int k;
        bit [63:0] span;
        int pick;
        pick = $urandom_range(0, 9);
        if (table_count == 0 || pick == 0)
            return $urandom;
        k = $urandom_range(0, table_count - 1);
        if (pick < 3 || k == table_count - 1)
            return table_x[k] + ((pick == 1) ? -1 : 0);
        span = longint'(table_x[k+1]) - longint'(table_x[k]);
        return table_x[k] + int'({$urandom, $urandom} % span);
    endfunction

    function automatic int pick_insert_x();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return $urandom;
        if (pick < 8 || table_count == 0)
            return ($urandom_range(0, 31) - 16) <<< 16;
        return table_x[$urandom_range(0, table_count - 1)];
    endfunction

    function automatic int pick_y();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return ($urandom_range(0, 255) - 128) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_random();
        int target;
        int ops;
        while (items_sent < RANDOM_ITEMS) begin
            quiet = ($urandom_range(0, 5) == 0);
            send_request(CMD_CLEAR, 0, 0);
            target = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 70)
                                                  : $urandom_range(1, 12);
            for (int i = 0; i < target + 2 && table_count < target; i++)
                send_request(CMD_INSERT, pick_insert_x(), pick_y());
            ops = $urandom_range(3, 20);
            for (int i = 0; i < ops; i++) begin
                case ($urandom_range(0, 9))
                    0, 1: send_request(CMD_STATS, $urandom, $urandom);
                    2: send_request(CMD_INSERT, pick_insert_x(), pick_y());
                    3: send_request(2'($urandom_range(0, 3)), $urandom, $urandom);
                    default: send_request(CMD_QUERY, pick_query_x(), $urandom);
                endcase
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_table();
        test_random();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
